### hdl/process_state_queue_manager_top_macros.svh
// Assertion macros for the process state queue manager.
// Used by the top level; no other dependencies.
`ifndef PROCESS_STATE_QUEUE_MANAGER_TOP_MACROS_SVH
`define PROCESS_STATE_QUEUE_MANAGER_TOP_MACROS_SVH

`ifndef SYNTH
`define PSQM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psqm check failed");
`define PSQM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("psqm check failed");
`else
`define PSQM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSQM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/psqm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the process state queue manager.
// No dependencies.
package psqm_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 8;
	localparam int ID_OUT_W    = 8;
	localparam int COUNT_W     = 5;

	typedef enum logic [2:0] {
		REQ_CREATE = 3'd0,
		REQ_STOP   = 3'd1,
		REQ_BLOCK  = 3'd2,
		REQ_WAKE   = 3'd3,
		REQ_SLICE  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NO_RUN = 2'd1,
		STAT_NO_BLK = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_state_t;

	typedef struct packed {
		logic [2:0]          req_type;
		logic [ID_OUT_W-1:0] proc_id;
	} in_word_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                running_valid;
		logic [ID_OUT_W-1:0] running_id;
		logic [COUNT_W-1:0]  ready_count;
		logic [COUNT_W-1:0]  blocked_count;
	} out_word_t;

	typedef struct packed {
		logic load_cmd;
		logic exec;
	} ctl_t;

endpackage

### hdl/psqm_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one word of a given payload type.
// No dependencies.
interface psqm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/psqm_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
// Uses psqm_pkg for default sizes.
module psqm_ram #(
	parameter int WIDTH = psqm_pkg::ID_WIDTH,
	parameter int DEPTH = psqm_pkg::QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/psqm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: takes a command word, runs it, owns result valid.
// Uses psqm_pkg.
module psqm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output psqm_pkg::ctl_t    ctl
);

	psqm_pkg::fsm_state_t state_q, state_n;
	logic                 out_valid_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			psqm_pkg::FSM_IDLE: begin
				if (in_valid) begin
					state_n = psqm_pkg::FSM_EXEC;
				end
			end
			psqm_pkg::FSM_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_n = psqm_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_n = psqm_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		ctl.load_cmd = 1'b0;
		ctl.exec     = 1'b0;
		case (state_q)
			psqm_pkg::FSM_IDLE: begin
				in_ready     = 1'b1;
				ctl.load_cmd = in_valid;
			end
			psqm_pkg::FSM_EXEC: begin
				ctl.exec = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psqm_pkg::FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/psqm_dp.sv
`timescale 1ns / 1ps
// Datapath: running slot, ready and blocked queues, command logic, result word.
// Uses psqm_pkg and psqm_ram.
module psqm_dp #(
	parameter int QUEUE_DEPTH = psqm_pkg::QUEUE_DEPTH,
	parameter int ID_WIDTH    = psqm_pkg::ID_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psqm_pkg::ctl_t      ctl,
	input  psqm_pkg::in_word_t  cmd_data,
	output psqm_pkg::out_word_t rsp_data
);

	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW  = psqm_pkg::COUNT_W;
	localparam int IDO = psqm_pkg::ID_OUT_W;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	logic [2:0]          req_q;
	logic [ID_WIDTH-1:0] pid_q;
	logic [ID_WIDTH-1:0] run_q, run_n;
	logic                pres_q, pres_n;
	logic [PW-1:0]       rdy_head_q, rdy_tail_q, blk_head_q, blk_tail_q;
	logic [CNW-1:0]      rdy_cnt_q, rdy_cnt_n, blk_cnt_q, blk_cnt_n;
	logic                rdy_push, rdy_pop, blk_push, blk_pop;
	logic [ID_WIDTH-1:0] rdy_wdata, rdy_rdata, blk_rdata;
	logic                rdy_full, blk_full;
	psqm_pkg::status_t   status_n;
	psqm_pkg::out_word_t out_q;

	psqm_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_rdy_ram (
		.clk     (clk),
		.wr_en   (ctl.exec && rdy_push),
		.wr_addr (rdy_tail_q),
		.wr_data (rdy_wdata),
		.rd_addr (rdy_head_q),
		.rd_data (rdy_rdata)
	);

	psqm_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_blk_ram (
		.clk     (clk),
		.wr_en   (ctl.exec && blk_push),
		.wr_addr (blk_tail_q),
		.wr_data (run_q),
		.rd_addr (blk_head_q),
		.rd_data (blk_rdata)
	);

	assign rdy_full = (rdy_cnt_q == CNW'(QUEUE_DEPTH));
	assign blk_full = (blk_cnt_q == CNW'(QUEUE_DEPTH));

	always_comb begin
		run_n     = run_q;
		pres_n    = pres_q;
		status_n  = psqm_pkg::STAT_OK;
		rdy_push  = 1'b0;
		rdy_pop   = 1'b0;
		blk_push  = 1'b0;
		blk_pop   = 1'b0;
		rdy_wdata = pid_q;
		case (req_q)
			psqm_pkg::REQ_CREATE: begin
				if (!pres_q) begin
					run_n  = pid_q;
					pres_n = 1'b1;
				end else if (rdy_full) begin
					status_n = psqm_pkg::STAT_FULL;
				end else begin
					rdy_push = 1'b1;
				end
			end
			psqm_pkg::REQ_STOP: begin
				if (!pres_q) begin
					status_n = psqm_pkg::STAT_NO_RUN;
				end else begin
					pres_n = 1'b0;
				end
			end
			psqm_pkg::REQ_BLOCK: begin
				if (!pres_q) begin
					status_n = psqm_pkg::STAT_NO_RUN;
				end else if (blk_full) begin
					status_n = psqm_pkg::STAT_FULL;
				end else begin
					blk_push = 1'b1;
					pres_n   = 1'b0;
				end
			end
			psqm_pkg::REQ_WAKE: begin
				if (blk_cnt_q == '0) begin
					status_n = psqm_pkg::STAT_NO_BLK;
				end else if (rdy_full) begin
					status_n = psqm_pkg::STAT_FULL;
				end else begin
					blk_pop = 1'b1;
					// With no process running the ready queue is empty, so the
					// woken process goes straight to the running slot.
					if (pres_q) begin
						rdy_push  = 1'b1;
						rdy_wdata = blk_rdata;
					end else begin
						run_n  = blk_rdata;
						pres_n = 1'b1;
					end
				end
			end
			psqm_pkg::REQ_SLICE: begin
				if (!pres_q) begin
					status_n = psqm_pkg::STAT_NO_RUN;
				end else if (rdy_cnt_q != '0) begin
					run_n     = rdy_rdata;
					rdy_pop   = 1'b1;
					rdy_push  = 1'b1;
					rdy_wdata = run_q;
				end
			end
			default: begin
				status_n = psqm_pkg::STAT_NO_RUN;
			end
		endcase
		if (!pres_n && rdy_cnt_q != '0) begin
			run_n   = rdy_rdata;
			pres_n  = 1'b1;
			rdy_pop = 1'b1;
		end
	end

	always_comb begin
		rdy_cnt_n = rdy_cnt_q;
		if (rdy_push && !rdy_pop) begin
			rdy_cnt_n = rdy_cnt_q + 1'b1;
		end else if (rdy_pop && !rdy_push) begin
			rdy_cnt_n = rdy_cnt_q - 1'b1;
		end
		blk_cnt_n = blk_cnt_q;
		if (blk_push) begin
			blk_cnt_n = blk_cnt_q + 1'b1;
		end else if (blk_pop) begin
			blk_cnt_n = blk_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_cmd) begin
			req_q <= cmd_data.req_type;
			pid_q <= ID_WIDTH'(cmd_data.proc_id);
		end
		if (ctl.exec) begin
			out_q.status        <= status_n;
			out_q.running_valid <= pres_n;
			out_q.running_id    <= pres_n ? IDO'(run_n) : '0;
			out_q.ready_count   <= CW'(rdy_cnt_n);
			out_q.blocked_count <= CW'(blk_cnt_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			pres_q     <= 1'b0;
			rdy_head_q <= '0;
			rdy_tail_q <= '0;
			rdy_cnt_q  <= '0;
			blk_head_q <= '0;
			blk_tail_q <= '0;
			blk_cnt_q  <= '0;
		end else if (ctl.exec) begin
			run_q     <= run_n;
			pres_q    <= pres_n;
			rdy_cnt_q <= rdy_cnt_n;
			blk_cnt_q <= blk_cnt_n;
			if (rdy_pop) begin
				rdy_head_q <= ptr_inc(rdy_head_q);
			end
			if (rdy_push) begin
				rdy_tail_q <= ptr_inc(rdy_tail_q);
			end
			if (blk_pop) begin
				blk_head_q <= ptr_inc(blk_head_q);
			end
			if (blk_push) begin
				blk_tail_q <= ptr_inc(blk_tail_q);
			end
		end
	end

	assign rsp_data = out_q;

endmodule

### hdl/process_state_queue_manager_top.sv
`timescale 1ns / 1ps
// Process state queue manager: one running slot plus ready and blocked ID queues.
// cmd takes a word with req_type and proc_id: create, stop, block, wake, time slice.
// rsp gives one word per command: status, running process, both queue counts.
// A command is taken in the idle state and executed in the exec state, so the
// block takes no new command until the last one has executed. This split is set
// by the registered read port of the queue RAMs: the head entries are read while
// the block waits for a command, and the data is used when the command executes.
// The result word is registered; cmd is ready again while it still waits on rsp.
// When rsp stalls with a result pending, the next command is taken but held in
// execution until the pending result is taken, so nothing is lost or reordered.
// Reset clears the running slot and empties both queues; the queue RAMs hold no
// reset value and need no clearing pass.
`include "process_state_queue_manager_top_macros.svh"
module process_state_queue_manager_top #(
	parameter int QUEUE_DEPTH = psqm_pkg::QUEUE_DEPTH,
	parameter int ID_WIDTH    = psqm_pkg::ID_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	psqm_chan_if.sink    cmd,
	psqm_chan_if.source  rsp
);

	psqm_pkg::ctl_t ctl;

	psqm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	psqm_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_WIDTH(ID_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd_data (cmd.data),
		.rsp_data (rsp.data)
	);

	`PSQM_ASSERT_NEXT(a_one_in_flight, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready)
	`PSQM_ASSERT_NEXT(a_exec_gives_rsp, clk, arst_n, ctl.exec, rsp.valid)
	`PSQM_ASSERT_IMP(a_idle_means_empty, clk, arst_n, rsp.valid && !rsp.data.running_valid, rsp.data.ready_count == '0)
	`PSQM_ASSERT_IMP(a_exec_not_blocked, clk, arst_n, ctl.exec && rsp.valid, rsp.ready)

endmodule

### bench/tb_process_state_queue_manager_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the process scheduler: directed, queue-limit, pressure and random tests.
// Depends on psqm_pkg, psqm_chan_if and process_state_queue_manager_top.
module tb_process_state_queue_manager_top;

	localparam logic [2:0] REQ_FIRST_ILLEGAL = 3'd5;
	localparam logic [2:0] REQ_MID_ILLEGAL   = 3'd6;
	localparam logic [2:0] REQ_LAST_ILLEGAL  = 3'd7;
	localparam int         HOLD_OFF_CYCLES   = 200;

	logic clk;
	logic arst_n;

	psqm_chan_if #(.T(psqm_pkg::in_word_t))  cmd_if ();
	psqm_chan_if #(.T(psqm_pkg::out_word_t)) rsp_if ();

	process_state_queue_manager_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	int        err_count;
	int        send_idle_pct;
	int        rsp_stall_pct;
	bit        hold_off_req;
	int        hold_off_left;

	logic                 sched_running;
	logic [7:0]           sched_running_id;
	logic [7:0]           ready_ids[$];
	logic [7:0]           blocked_ids[$];
	psqm_pkg::out_word_t  expected_words[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL process_state_queue_manager_top");
		$finish;
	end

	initial begin
		rsp_if.ready <= 1'b0;
		hold_off_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			err_count++;
		end
	endtask

	task automatic schedule_cmd(input psqm_pkg::in_word_t w);
		psqm_pkg::status_t   st;
		psqm_pkg::out_word_t o;
		st = psqm_pkg::STAT_OK;
		case (w.req_type)
			psqm_pkg::REQ_CREATE: begin
				if (!sched_running) begin
					sched_running = 1'b1;
					sched_running_id = w.proc_id;
				end else if (ready_ids.size() >= psqm_pkg::QUEUE_DEPTH) begin
					st = psqm_pkg::STAT_FULL;
				end else begin
					ready_ids.push_back(w.proc_id);
				end
			end
			psqm_pkg::REQ_STOP: begin
				if (!sched_running) st = psqm_pkg::STAT_NO_RUN;
				else sched_running = 1'b0;
			end
			psqm_pkg::REQ_BLOCK: begin
				if (!sched_running) begin
					st = psqm_pkg::STAT_NO_RUN;
				end else if (blocked_ids.size() >= psqm_pkg::QUEUE_DEPTH) begin
					st = psqm_pkg::STAT_FULL;
				end else begin
					blocked_ids.push_back(sched_running_id);
					sched_running = 1'b0;
				end
			end
			psqm_pkg::REQ_WAKE: begin
				if (blocked_ids.size() == 0) st = psqm_pkg::STAT_NO_BLK;
				else if (ready_ids.size() >= psqm_pkg::QUEUE_DEPTH) st = psqm_pkg::STAT_FULL;
				else ready_ids.push_back(blocked_ids.pop_front());
			end
			psqm_pkg::REQ_SLICE: begin
				if (!sched_running) begin
					st = psqm_pkg::STAT_NO_RUN;
				end else if (ready_ids.size() != 0) begin
					ready_ids.push_back(sched_running_id);
					sched_running_id = ready_ids.pop_front();
				end
			end
			default: st = psqm_pkg::STAT_NO_RUN;
		endcase
		if (!sched_running && ready_ids.size() != 0) begin
			sched_running_id = ready_ids.pop_front();
			sched_running = 1'b1;
		end
		o.status        = st;
		o.running_valid = sched_running;
		o.running_id    = sched_running ? sched_running_id : '0;
		o.ready_count   = psqm_pkg::COUNT_W'(ready_ids.size());
		o.blocked_count = psqm_pkg::COUNT_W'(blocked_ids.size());
		expected_words.push_back(o);
	endtask

	always @(posedge clk) begin
		psqm_pkg::out_word_t e;
		psqm_pkg::out_word_t a;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				a = rsp_if.data;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %0h", $time, a);
					err_count++;
				end else begin
					e = expected_words.pop_front();
					check_field("status", e.status, a.status);
					check_field("running_valid", e.running_valid, a.running_valid);
					check_field("running_id", e.running_id, a.running_id);
					check_field("ready_count", e.ready_count, a.ready_count);
					check_field("blocked_count", e.blocked_count, a.blocked_count);
				end
			end
			if (cmd_if.valid && cmd_if.ready) schedule_cmd(cmd_if.data);
		end
	end

	task automatic send_cmd(input logic [2:0] req, input logic [7:0] pid);
		psqm_pkg::in_word_t w;
		w.req_type = req;
		w.proc_id  = pid;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= w;
		do @(posedge clk); while (!cmd_if.ready);
	endtask

	task automatic send_other(input logic [2:0] req);
		send_cmd(req, 8'($urandom_range(255)));
	endtask

	task automatic test_directed();
		send_other(psqm_pkg::REQ_STOP);
		send_other(psqm_pkg::REQ_BLOCK);
		send_other(psqm_pkg::REQ_SLICE);
		send_other(psqm_pkg::REQ_WAKE);
		send_other(REQ_FIRST_ILLEGAL);
		send_other(REQ_LAST_ILLEGAL);
		send_cmd(psqm_pkg::REQ_CREATE, 8'h00);
		send_other(psqm_pkg::REQ_SLICE);
		send_cmd(psqm_pkg::REQ_CREATE, 8'hFF);
		send_cmd(psqm_pkg::REQ_CREATE, 8'h5A);
		send_other(psqm_pkg::REQ_SLICE);
		send_other(REQ_MID_ILLEGAL);
		send_other(psqm_pkg::REQ_BLOCK);
		send_other(psqm_pkg::REQ_BLOCK);
		send_other(psqm_pkg::REQ_WAKE);
		send_cmd(psqm_pkg::REQ_CREATE, 8'hA5);
		send_other(psqm_pkg::REQ_STOP);
		send_other(psqm_pkg::REQ_WAKE);
		send_other(psqm_pkg::REQ_STOP);
		send_other(psqm_pkg::REQ_STOP);
		send_other(psqm_pkg::REQ_STOP);
		send_other(psqm_pkg::REQ_STOP);
	endtask

	task automatic test_queue_limits();
		for (int i = 0; i < psqm_pkg::QUEUE_DEPTH + 1; i++)
			send_cmd(psqm_pkg::REQ_CREATE, 8'($urandom_range(255)));
		for (int i = 0; i < psqm_pkg::QUEUE_DEPTH + 1; i++) send_other(psqm_pkg::REQ_BLOCK);
		for (int i = 0; i < psqm_pkg::QUEUE_DEPTH + 1; i++)
			send_cmd(psqm_pkg::REQ_CREATE, 8'($urandom_range(255)));
		send_other(psqm_pkg::REQ_WAKE);
		send_other(psqm_pkg::REQ_SLICE);
		send_other(psqm_pkg::REQ_SLICE);
		for (int i = 0; i < psqm_pkg::QUEUE_DEPTH + 2; i++) send_other(psqm_pkg::REQ_STOP);
		for (int i = 0; i < psqm_pkg::QUEUE_DEPTH + 1; i++) send_other(psqm_pkg::REQ_WAKE);
		for (int i = 0; i < psqm_pkg::QUEUE_DEPTH + 1; i++) send_other(psqm_pkg::REQ_STOP);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_off_req  = 1'b1;
		for (int i = 0; i < 40; i++) begin
			if (i % 3 == 2) send_other(psqm_pkg::REQ_SLICE);
			else send_cmd(psqm_pkg::REQ_CREATE, 8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int n, input int create_pct);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(19);
			if ($urandom_range(99) < create_pct)
				send_cmd(psqm_pkg::REQ_CREATE, 8'($urandom_range(255)));
			else if (r < 4) send_other(psqm_pkg::REQ_STOP);
			else if (r < 9) send_other(psqm_pkg::REQ_BLOCK);
			else if (r < 14) send_other(psqm_pkg::REQ_WAKE);
			else if (r < 19) send_other(psqm_pkg::REQ_SLICE);
			else send_other(3'($urandom_range(REQ_FIRST_ILLEGAL, REQ_LAST_ILLEGAL)));
		end
	endtask

	task automatic test_random(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
		run_random(60, 55);
		run_random(60, 20);
		run_random(60, 40);
	endtask

	initial begin
		err_count     = 0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_off_req  = 1'b0;
		sched_running = 1'b0;
		sched_running_id = '0;
		arst_n        <= 1'b0;
		cmd_if.valid  <= 1'b0;
		cmd_if.data   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_queue_limits();
		test_backpressure();
		test_random(0, 0);
		test_random(81, 0);
		test_random(0, 81);
		test_random(8, 8);
		cmd_if.valid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("PASS process_state_queue_manager_top");
		end else begin
			$display("FAIL process_state_queue_manager_top");
		end
		$finish;
	end
endmodule
